FILE: rtl/luex_pkg.sv
package luex_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] LINK_LOOPBACK = 8'd0;
   localparam logic [7:0] LINK_ETHERNET = 8'd1;
   localparam logic [7:0] LINK_RAW_IP = 8'd101;
   localparam logic [7:0] LINK_SEL_RESET = LINK_ETHERNET;

   localparam logic [15:0] ETH_VLAN_TPID = 16'h8100;
   localparam logic [15:0] ETH_IPV4_TYPE = 16'h0800;
   localparam logic [7:0] IP_PROTO_UDP = 8'd17;
   localparam logic [15:0] ETH_HDR_LEN = 16'd14;
   localparam logic [15:0] IP_MIN_HDR = 16'd20;
   localparam logic [15:0] UDP_HDR_LEN = 16'd8;

   localparam logic [0:0] REG_LINK_SEL = 1'b0;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_BAD_LINK = 4'd1;
   localparam logic [3:0] ST_SHORT_LINK = 4'd2;
   localparam logic [3:0] ST_FAMILY = 4'd3;
   localparam logic [3:0] ST_ETHERTYPE = 4'd4;
   localparam logic [3:0] ST_SHORT_IP = 4'd5;
   localparam logic [3:0] ST_IHL = 4'd6;
   localparam logic [3:0] ST_VERSION = 4'd7;
   localparam logic [3:0] ST_PROTOCOL = 4'd8;
   localparam logic [3:0] ST_TOTAL_LEN = 4'd9;
   localparam logic [3:0] ST_UDP_LEN = 4'd10;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_payload_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic        last_item;
      logic [3:0]  status_code;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] payload_length;
   } rsp_payload_type;

   // One entry per accepted byte that produces anything.
   typedef struct packed {
      logic        pay_valid;
      logic [7:0]  pay_byte;
      logic        ver_valid;
      logic [3:0]  status;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] pay_len;
   } queue_entry_type;

endpackage

FILE: rtl/luex_front.sv
module luex_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               link_sel,
   input  logic                     accept,
   input  luex_pkg::req_payload_type in_data,
   output logic                     push,
   output luex_pkg::queue_entry_type push_entry
);
   import luex_pkg::*;

   localparam logic [1:0] PH_LINK = 2'd0;
   localparam logic [1:0] PH_VLAN = 2'd1;
   localparam logic [1:0] PH_IP = 2'd2;

   logic [15:0] count_ff, count_in;
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  ipstart_ff, ipstart_in;
   logic [31:0] held_ff, held_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] ulen_ff, ulen_in;
   logic [31:0] addr0_ff, addr0_in, addr1_ff, addr1_in;
   logic [15:0] port0_ff, port0_in, port1_ff, port1_in;
   logic [3:0]  early_ff, early_in;

   logic [15:0] pos, rel, hl, et, ipstart_w;
   logic [3:0]  code;

   function automatic logic doomed_f(input logic [7:0] vihl, input logic [7:0] proto,
                                     input logic [15:0] tlen, input logic [15:0] ulen);
      logic [15:0] h;
      logic        d;
      h = {10'd0, vihl[3:0], 2'b00};
      d = 1'b0;
      if (h < IP_MIN_HDR) d = 1'b1;
      else if (vihl[7:4] != 4'd4) d = 1'b1;
      else if (proto != IP_PROTO_UDP) d = 1'b1;
      else if ({1'b0, tlen} < {1'b0, h} + {1'b0, UDP_HDR_LEN}) d = 1'b1;
      else if (ulen < UDP_HDR_LEN || ulen > tlen - h) d = 1'b1;
      return d;
   endfunction

   function automatic logic [3:0] code_f(input logic [3:0] early, input logic [1:0] phase,
                                         input logic [15:0] size, input logic [4:0] ips,
                                         input logic [7:0] vihl, input logic [7:0] proto,
                                         input logic [15:0] tlen, input logic [15:0] ulen);
      logic [15:0] ip_len, h;
      logic [3:0]  c;
      h = {10'd0, vihl[3:0], 2'b00};
      ip_len = (size >= {11'd0, ips}) ? size - {11'd0, ips} : 16'd0;
      if (early != ST_OK) c = early;
      else if (phase != PH_IP) c = ST_SHORT_LINK;
      else if (ip_len < IP_MIN_HDR) c = ST_SHORT_IP;
      else if (h < IP_MIN_HDR || ip_len < h) c = ST_IHL;
      else if (vihl[7:4] != 4'd4) c = ST_VERSION;
      else if (proto != IP_PROTO_UDP) c = ST_PROTOCOL;
      else if ({1'b0, tlen} < {1'b0, h} + {1'b0, UDP_HDR_LEN} || ip_len < tlen)
         c = ST_TOTAL_LEN;
      else if (ulen < UDP_HDR_LEN || ulen > tlen - h) c = ST_UDP_LEN;
      else c = ST_OK;
      return c;
   endfunction

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      ipstart_in = ipstart_ff;
      held_in = held_ff;
      vihl_in = vihl_ff;
      proto_in = proto_ff;
      tlen_in = tlen_ff;
      ulen_in = ulen_ff;
      addr0_in = addr0_ff;
      addr1_in = addr1_ff;
      port0_in = port0_ff;
      port1_in = port1_ff;
      early_in = early_ff;
      push_entry = '0;
      push = 1'b0;
      pos = count_ff;
      et = held_ff[15:0];
      rel = 16'd0;
      hl = 16'd0;
      ipstart_w = 16'd0;
      code = ST_OK;

      if (accept) begin
         held_in = {held_ff[23:0], in_data.frame_byte};
         et = held_in[15:0];
         // Bytes past the saturated count are neither examined nor emitted.
         if (count_ff != 16'hffff) begin
            count_in = count_ff + 16'd1;
            if (early_ff == ST_OK) begin
               if (phase_ff == PH_LINK) begin
                  priority if (link_sel == LINK_RAW_IP) begin
                     if (pos == 16'd0) begin
                        phase_in = PH_IP;
                        ipstart_in = 5'd0;
                     end
                  end else if (link_sel == LINK_LOOPBACK) begin
                     if (pos == 16'd3) begin
                        if (held_in != 32'd2) early_in = ST_FAMILY;
                        else begin
                           phase_in = PH_IP;
                           ipstart_in = 5'd4;
                        end
                     end
                  end else if (link_sel == LINK_ETHERNET) begin
                     if (pos == ETH_HDR_LEN - 16'd1) begin
                        if (et == ETH_VLAN_TPID) phase_in = PH_VLAN;
                        else if (et != ETH_IPV4_TYPE) early_in = ST_ETHERTYPE;
                        else begin
                           phase_in = PH_IP;
                           ipstart_in = ETH_HDR_LEN[4:0];
                        end
                     end
                  end else begin
                     early_in = ST_BAD_LINK;
                  end
               end else if (phase_ff == PH_VLAN) begin
                  if (pos == ETH_HDR_LEN + 16'd3) begin
                     if (et != ETH_IPV4_TYPE) early_in = ST_ETHERTYPE;
                     else begin
                        phase_in = PH_IP;
                        ipstart_in = 5'(ETH_HDR_LEN + 16'd4);
                     end
                  end
               end

               ipstart_w = {11'd0, ipstart_in};
               if (early_in == ST_OK && phase_in == PH_IP && pos >= ipstart_w) begin
                  rel = pos - ipstart_w;
                  priority if (rel == 16'd0) vihl_in = in_data.frame_byte;
                  else if (rel == 16'd3) tlen_in = held_in[15:0];
                  else if (rel == 16'd9) proto_in = in_data.frame_byte;
                  else if (rel == 16'd15) addr0_in = held_in;
                  else if (rel == 16'd19) addr1_in = held_in;
                  else begin
                  end
                  hl = {10'd0, vihl_in[3:0], 2'b00};
                  if (hl >= IP_MIN_HDR) begin
                     priority if (rel == hl + 16'd1) port0_in = held_in[15:0];
                     else if (rel == hl + 16'd3) port1_in = held_in[15:0];
                     else if (rel == hl + 16'd5) ulen_in = held_in[15:0];
                     else if (rel >= hl + UDP_HDR_LEN
                              && {1'b0, rel} < {1'b0, hl} + {1'b0, ulen_ff}
                              && !doomed_f(vihl_in, proto_in, tlen_in, ulen_ff)) begin
                        push_entry.pay_valid = 1'b1;
                        push_entry.pay_byte = in_data.frame_byte;
                     end else begin
                     end
                  end
               end
            end
         end

         if (in_data.frame_end) begin
            code = code_f(early_in, phase_in, count_in, ipstart_in, vihl_in, proto_in,
                          tlen_in, ulen_in);
            push_entry.ver_valid = 1'b1;
            push_entry.status = code;
            push_entry.src_addr = addr0_in;
            push_entry.dst_addr = addr1_in;
            push_entry.sport = port0_in;
            push_entry.dport = port1_in;
            push_entry.pay_len = (code == ST_OK) ? ulen_in - UDP_HDR_LEN : 16'd0;
            count_in = '0;
            phase_in = PH_LINK;
            ipstart_in = '0;
            held_in = '0;
            vihl_in = '0;
            proto_in = '0;
            tlen_in = '0;
            ulen_in = '0;
            addr0_in = '0;
            addr1_in = '0;
            port0_in = '0;
            port1_in = '0;
            early_in = ST_OK;
         end
         push = push_entry.pay_valid | push_entry.ver_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= PH_LINK;
         ipstart_ff <= '0;
         held_ff <= '0;
         vihl_ff <= '0;
         proto_ff <= '0;
         tlen_ff <= '0;
         ulen_ff <= '0;
         addr0_ff <= '0;
         addr1_ff <= '0;
         port0_ff <= '0;
         port1_ff <= '0;
         early_ff <= ST_OK;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         ipstart_ff <= ipstart_in;
         held_ff <= held_in;
         vihl_ff <= vihl_in;
         proto_ff <= proto_in;
         tlen_ff <= tlen_in;
         ulen_ff <= ulen_in;
         addr0_ff <= addr0_in;
         addr1_ff <= addr1_in;
         port0_ff <= port0_in;
         port1_ff <= port1_in;
         early_ff <= early_in;
      end
   end

endmodule

FILE: rtl/luex_queue.sv
module luex_queue #(
   parameter int DEPTH = luex_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  luex_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output luex_pkg::queue_entry_type head,
   output logic                      full,
   output logic                      empty
);
   import luex_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   queue_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST) ? '0 : wr_ff + PW'(1);
      if (pop) rd_in = (rd_ff == LAST) ? '0 : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from an empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("queue count did not advance on push");

endmodule

FILE: rtl/luex_back.sv
module luex_back (
   input  logic                      clock,
   input  logic                      reset,
   input  luex_pkg::queue_entry_type head,
   input  logic                      head_valid,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output luex_pkg::rsp_payload_type rsp_data
);
   import luex_pkg::*;

   logic            valid_ff, valid_in;
   logic            sent_ff, sent_in;
   rsp_payload_type data_ff, data_in;
   logic            can_load;

   assign can_load = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   always_comb begin
      pop = 1'b0;
      sent_in = sent_ff;
      data_in = data_ff;
      valid_in = valid_ff && !rsp_ready;
      if (can_load && head_valid) begin
         valid_in = 1'b1;
         data_in = '0;
         // A byte that both carries payload and ends the frame yields two words.
         if (head.pay_valid && !sent_ff) begin
            data_in.item_kind = KIND_PAYLOAD;
            data_in.payload_byte = head.pay_byte;
            if (head.ver_valid) sent_in = 1'b1;
            else pop = 1'b1;
         end else begin
            data_in.item_kind = KIND_VERDICT;
            data_in.last_item = 1'b1;
            data_in.status_code = head.status;
            data_in.source_address = head.src_addr;
            data_in.destination_address = head.dst_addr;
            data_in.source_port = head.sport;
            data_in.destination_port = head.dport;
            data_in.payload_length = head.pay_len;
            sent_in = 1'b0;
            pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: rtl/link_ipv4_udp_payload_extractor_core.sv
// Channel   Direction  Handshake           Carries
// req_      in         req_valid/ready     one frame byte and its end mark
// rsp_      out        rsp_valid/ready     payload byte or end-of-frame verdict
// csr       in/out     psel/penable/pwrite link select register at address 0
//
// Each byte is parsed in the cycle it is accepted; one byte per clock is taken while the queue is not full.
// A byte that carries payload and ends the frame yields two words, which the output
// side sends one after the other; a small queue absorbs this and output stalls.
// req_ready drops only when the queue between parser and output stage is full.
// Reset is synchronous and clears all parse state and sets the link select to Ethernet.
module link_ipv4_udp_payload_extractor_core #(
   parameter int QUEUE_DEPTH = luex_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  luex_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output luex_pkg::rsp_payload_type rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import luex_pkg::*;

   logic [7:0]      link_ff;
   logic            accept, push, pop, full, empty;
   queue_entry_type push_entry, head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_LINK_SEL) ? {24'd0, link_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) link_ff <= LINK_SEL_RESET;
      else if (psel && penable && pwrite && paddr[2] == REG_LINK_SEL)
         link_ff <= pwdata[7:0];
   end

   assign req_ready = !full;
   assign accept = req_valid && req_ready;

   luex_front u_front (
      .clock(clock), .reset(reset), .link_sel(link_ff), .accept(accept),
      .in_data(req_data), .push(push), .push_entry(push_entry)
   );

   luex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .pop(pop), .head(head), .full(full), .empty(empty)
   );

   luex_back u_back (
      .clock(clock), .reset(reset), .head(head), .head_valid(!empty), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule
